>>> rtl/protobuf_field_flag_scanner_core_macros.svh
// Assertion macros shared by the scanner RTL.
`ifndef PROTOBUF_FIELD_FLAG_SCANNER_CORE_MACROS_SVH
`define PROTOBUF_FIELD_FLAG_SCANNER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define PFFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a rising edge outside reset.
`define PFFS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define PFFS_ASSERT(label, clk, rst_n, prop, msg)
`define PFFS_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/pffs_pkg.sv
`default_nettype none

package pffs_pkg;

    localparam int unsigned ACC_W    = 64;
    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned SKIP_W   = 31;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned SHIFT_W  = 7;

    localparam logic [COUNT_W-1:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [FIELD_W-1:0] TARGET_RESET     = 32'd7;
    localparam logic [SKIP_W-1:0]  SKIP_FIXED64     = 31'd8;
    localparam logic [SKIP_W-1:0]  SKIP_FIXED32     = 31'd4;

    localparam logic [2:0] WT_VARINT  = 3'd0;
    localparam logic [2:0] WT_FIXED64 = 3'd1;
    localparam logic [2:0] WT_LEN     = 3'd2;
    localparam logic [2:0] WT_FIXED32 = 3'd5;

    typedef enum logic [1:0] {
        PH_TAG   = 2'd0,
        PH_VALUE = 2'd1,
        PH_LEN   = 2'd2,
        PH_SKIP  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_ENDED = 2'd1,
        ST_BAD   = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> rtl/protobuf_field_flag_scanner_core.sv
// Protobuf wire-format field scanner.
// Input channel (i_in_valid/o_in_ready) carries one buffer byte per word with
// i_last_byte marking the final byte. Output channel (o_out_valid/i_out_ready)
// carries at most one result word per buffer: o_status says whether the target
// field was found (o_verdict = value nonzero), the buffer ended without it, or
// the buffer was malformed. i_cfg_wr_en/i_cfg_wr_data set the target field
// number; write it only while the block is idle.
// A byte accepted into the input register is scanned into the result register
// once that register is empty or being read; its result word is then offered.
// Throughput: one byte per cycle while the result is not stalled; the tag, length
// and value varint logic plus the skip counter all settle combinationally between
// the input register and the result register.
// The input register refills whenever it is scanned in the same cycle, so a
// stalled result only blocks new bytes once the input register also holds one.
// Reset (synchronous, active low) clears both registers, the scan state and
// sets the target field number to 7.
`default_nettype none

`include "protobuf_field_flag_scanner_core_macros.svh"

module protobuf_field_flag_scanner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_verdict,
    output logic [1:0]  o_status
);
    import pffs_pkg::*;

    // Input register.
    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;

    // Scan state.
    t_phase             r_phase,   n_phase;
    logic [ACC_W-1:0]   r_acc,     n_acc;
    logic [COUNT_W-1:0] r_count,   n_count;
    logic               r_match,   n_match;
    logic [SKIP_W-1:0]  r_skip,    n_skip;
    logic               r_decided, n_decided;
    logic [FIELD_W-1:0] r_target;

    // Result register.
    logic               r_out_valid;
    logic               r_out_verdict;
    t_status            r_out_status;

    logic               w_go;
    logic               w_emit;
    t_status            w_status;
    logic               w_verdict;
    logic [SHIFT_W-1:0] w_shift;
    logic [ACC_W-1:0]   w_value;
    logic [COUNT_W-1:0] w_count_inc;

    assign w_go       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_go;

    assign w_shift     = SHIFT_W'(r_count) * SHIFT_W'(7);
    // Bits shifted past bit 63 drop, so the tenth byte keeps only bit 0.
    assign w_value     = r_acc | ({{(ACC_W-7){1'b0}}, r_in_byte[6:0]} << w_shift);
    assign w_count_inc = r_count + COUNT_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_count   = r_count;
        n_match   = r_match;
        n_skip    = r_skip;
        n_decided = r_decided;
        w_status  = ST_NONE;
        w_verdict = 1'b0;

        if (!r_decided) begin
            unique case (r_phase)
                PH_SKIP: begin
                    if (r_skip != '0) begin
                        n_skip = r_skip - SKIP_W'(1);
                    end
                    if (r_skip <= SKIP_W'(1)) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_TAG, PH_VALUE, PH_LEN: begin
                    n_acc = w_value;
                    if (r_in_byte[7]) begin
                        n_count = w_count_inc;
                        if (w_count_inc >= VARINT_MAX_BYTES) begin
                            w_status = ST_BAD;
                        end
                    end else begin
                        n_acc   = '0;
                        n_count = '0;
                        if (r_phase == PH_VALUE) begin
                            if (r_match) begin
                                w_status  = ST_FOUND;
                                w_verdict = |w_value;
                            end else begin
                                n_phase = PH_TAG;
                            end
                        end else if (r_phase == PH_LEN) begin
                            if (|w_value[ACC_W-1:SKIP_W]) begin
                                w_status = ST_BAD;
                            end else if (w_value == '0) begin
                                n_phase = PH_TAG;
                            end else begin
                                n_skip  = w_value[SKIP_W-1:0];
                                n_phase = PH_SKIP;
                            end
                        end else begin
                            n_match = (w_value[FIELD_W+2:3] == r_target);
                            case (w_value[2:0])
                                WT_VARINT:  n_phase = PH_VALUE;
                                WT_FIXED64: begin
                                    n_skip  = SKIP_FIXED64;
                                    n_phase = PH_SKIP;
                                end
                                WT_LEN:     n_phase = PH_LEN;
                                WT_FIXED32: begin
                                    n_skip  = SKIP_FIXED32;
                                    n_phase = PH_SKIP;
                                end
                                default:    w_status = ST_BAD;
                            endcase
                        end
                    end
                end
            endcase

            if (w_status == ST_NONE && r_in_last) begin
                if (n_phase == PH_TAG && n_count == '0) begin
                    w_status = ST_ENDED;
                end else begin
                    w_status = ST_BAD;
                end
            end

            if (w_status != ST_NONE) begin
                n_decided = 1'b1;
            end
        end

        // The last byte always leaves the scanner clean for the next buffer.
        if (r_in_last) begin
            n_phase   = PH_TAG;
            n_acc     = '0;
            n_count   = '0;
            n_match   = 1'b0;
            n_skip    = '0;
            n_decided = 1'b0;
        end
    end

    assign w_emit = (w_status != ST_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TAG;
            r_acc     <= '0;
            r_count   <= '0;
            r_match   <= 1'b0;
            r_skip    <= '0;
            r_decided <= 1'b0;
        end else if (w_go) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_count   <= n_count;
            r_match   <= n_match;
            r_skip    <= n_skip;
            r_decided <= n_decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_go && w_emit) begin
            r_out_verdict <= w_verdict;
            r_out_status  <= w_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;
    assign o_status    = r_out_status;

    // A skip in progress always has bytes left to skip.
    `PFFS_ASSERT(a_skip_nonzero, i_clk, i_rst_n,
        r_phase == PH_SKIP |-> r_skip != '0, "skip phase with zero count")
    // A varint longer than ten bytes is caught before the count goes further.
    `PFFS_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= VARINT_MAX_BYTES, "varint byte count overran")
    // Only a found field can carry a true verdict.
    `PFFS_ASSERT(a_verdict_found, i_clk, i_rst_n,
        r_out_valid && r_out_status != ST_FOUND |-> !r_out_verdict,
        "verdict set without found status")
    // Scanning the last byte of a buffer leaves the scanner clean.
    `PFFS_ASSERT(a_last_clears, i_clk, i_rst_n,
        w_go && r_in_last |=> r_phase == PH_TAG && r_count == '0 && !r_decided,
        "scanner not cleared after last byte")

endmodule

`default_nettype wire

>>> dv/tb_protobuf_field_flag_scanner_core.sv
`timescale 1ns / 1ps

module tb_protobuf_field_flag_scanner_core;
    import pffs_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } byte_word_t;

    typedef struct packed {
        logic    verdict;
        t_status status;
    } scan_result_t;

    localparam logic [2:0] WT_INVALID [4] = '{3'd3, 3'd4, 3'd6, 3'd7};
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_BYTES = 1150;
    localparam int unsigned DRAIN_CYCLES = 6;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_byte_value = '0;
    logic        i_last_byte = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_verdict;
    logic [1:0]  o_status;

    protobuf_field_flag_scanner_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_value  (i_byte_value),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_verdict     (o_verdict),
        .o_status      (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Scanner copy kept by the testbench.
    logic [31:0] target_q = TARGET_RESET;
    t_phase      sc_phase;
    logic [63:0] sc_acc;
    logic [3:0]  sc_count;
    logic        sc_match;
    logic [31:0] sc_skip;
    logic        sc_decided;

    scan_result_t exp_results[$];
    byte_word_t   pending_words[$];
    logic [7:0]   buf_q[$];

    byte_word_t   cur_word = '0;
    scan_result_t want;
    int           scanned_bytes = 0;
    int           err_cnt = 0;

    bit in_busy = 1'b0;
    bit in_taken = 1'b0;
    int in_gap = 0;
    int in_max = 19;
    bit out_taken = 1'b0;
    int out_gap = 0;
    int out_max = 19;
    bit hold_req = 1'b0;
    int hold_left = 0;

    task automatic clear_scan();
        sc_phase   = PH_TAG;
        sc_acc     = '0;
        sc_count   = '0;
        sc_match   = 1'b0;
        sc_skip    = '0;
        sc_decided = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] b, input logic last);
        t_status     st;
        logic        verd;
        logic [63:0] v;
        int          shamt;
        st   = ST_NONE;
        verd = 1'b0;
        scanned_bytes++;
        if (sc_decided) begin
            if (last)
                clear_scan();
        end else begin
            if (sc_phase == PH_SKIP) begin
                if (sc_skip != 0)
                    sc_skip--;
                if (sc_skip == 0)
                    sc_phase = PH_TAG;
            end else begin
                shamt = int'(sc_count) * 7;
                if (shamt < 64)
                    sc_acc |= 64'(b[6:0]) << shamt;
                if (b[7]) begin
                    sc_count++;
                    if (sc_count >= VARINT_MAX_BYTES)
                        st = ST_BAD;
                end else begin
                    v        = sc_acc;
                    sc_acc   = '0;
                    sc_count = '0;
                    case (sc_phase)
                        PH_VALUE: begin
                            if (sc_match) begin
                                st   = ST_FOUND;
                                verd = (v != 0);
                            end else begin
                                sc_phase = PH_TAG;
                            end
                        end
                        PH_LEN: begin
                            if (v > 64'h7FFF_FFFF) begin
                                st = ST_BAD;
                            end else if (v == 0) begin
                                sc_phase = PH_TAG;
                            end else begin
                                sc_skip  = v[31:0];
                                sc_phase = PH_SKIP;
                            end
                        end
                        default: begin
                            // The field number is cut to 32 bits before the compare.
                            sc_match = (v[34:3] == target_q);
                            case (v[2:0])
                                WT_VARINT: sc_phase = PH_VALUE;
                                WT_FIXED64: begin
                                    sc_skip  = 32'(SKIP_FIXED64);
                                    sc_phase = PH_SKIP;
                                end
                                WT_LEN: sc_phase = PH_LEN;
                                WT_FIXED32: begin
                                    sc_skip  = 32'(SKIP_FIXED32);
                                    sc_phase = PH_SKIP;
                                end
                                default: st = ST_BAD;
                            endcase
                        end
                    endcase
                end
            end
            if (st == ST_NONE && last)
                st = (sc_phase == PH_TAG && sc_count == 0) ? ST_ENDED : ST_BAD;
            if (st != ST_NONE) begin
                exp_results.insert(exp_results.size(),
                                   scan_result_t'{verdict: verd, status: st});
                if (last)
                    clear_scan();
                else
                    sc_decided = 1'b1;
            end
        end
    endtask

    // Input side: one word per buffer byte, with a random gap after each.
    always @(negedge i_clk) begin
        if (in_taken) begin
            in_busy  = 1'b0;
            in_taken = 1'b0;
        end
        if (!in_busy) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_words.size() > 0) begin
                cur_word = pending_words.pop_front();
                in_busy  = 1'b1;
                in_gap   = $urandom_range(0, in_max);
            end
        end
        i_in_valid   <= in_busy;
        i_byte_value <= cur_word.value;
        i_last_byte  <= cur_word.last;
    end

    // Output side: ready drops for a random gap after each word, or for a long hold.
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            out_gap   = $urandom_range(0, out_max);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                out_taken = 1'b1;
                if (exp_results.size() == 0) begin
                    $error("unexpected result word: verdict %0d status %0d",
                           o_verdict, o_status);
                    err_cnt++;
                end else begin
                    want = exp_results.pop_front();
                    if (o_verdict !== want.verdict) begin
                        $error("verdict: expected %0d, actual %0d", want.verdict, o_verdict);
                        err_cnt++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        err_cnt++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                scan_byte(i_byte_value, i_last_byte);
            end
        end
    end

    task automatic push_varint(input logic [63:0] v, input int pad);
        int n;
        int total;
        n = 1;
        while (n < 10 && (v >> (7 * n)) != 0)
            n++;
        total = (n + pad > 10) ? 10 : n + pad;
        for (int i = 0; i < total; i++)
            buf_q.insert(buf_q.size(),
                         {1'(i < total - 1), 7'((v >> (7 * i)) & 64'h7F)});
    endtask

    function automatic int rand_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return 64'd1;
            2, 3: return 64'($urandom_range(0, 300));
            4: return 64'($urandom);
            5: return {$urandom, $urandom};
            6: return '1;
            default: return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    task automatic push_random_bytes(input int n);
        repeat (n) buf_q.insert(buf_q.size(), 8'($urandom));
    endtask

    task automatic gen_field();
        logic [63:0] fnum;
        logic [2:0]  wt;
        int          r;
        int          len;
        case ($urandom_range(0, 9))
            0, 1, 2: fnum = 64'(target_q);
            3: fnum = 64'(target_q) + 1;
            4: fnum = 64'($urandom);
            // Tag bits above the 32-bit field number must be dropped.
            5: fnum = {3'b000, 29'($urandom) | 29'd1, target_q};
            default: fnum = 64'($urandom_range(0, 15));
        endcase
        r = $urandom_range(0, 19);
        if (r < 8)
            wt = WT_VARINT;
        else if (r < 10)
            wt = WT_FIXED64;
        else if (r < 12)
            wt = WT_FIXED32;
        else if (r < 16)
            wt = WT_LEN;
        else if (r == 16)
            wt = WT_INVALID[$urandom_range(0, 3)];
        else
            wt = WT_VARINT;
        push_varint((fnum << 3) | 64'(wt), rand_pad());
        case (wt)
            WT_VARINT: push_varint(rand_value(), rand_pad());
            WT_FIXED64: push_random_bytes(8);
            WT_FIXED32: push_random_bytes(4);
            WT_LEN: begin
                r = $urandom_range(0, 9);
                if (r == 0) begin
                    push_varint(64'd0, rand_pad());
                end else if (r == 1) begin
                    push_varint($urandom_range(0, 1) ? 64'h8000_0000
                                : ({$urandom, $urandom} | 64'h8000_0000), 0);
                end else begin
                    len = $urandom_range(1, 6);
                    push_varint(64'(len), rand_pad());
                    push_random_bytes(len);
                end
            end
            default: ;
        endcase
    endtask

    task automatic gen_buffer();
        int r;
        int drop;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            push_random_bytes($urandom_range(1, 8));
        end else if (r == 1) begin
            // Value varint that never terminates within ten bytes.
            push_varint(64'(target_q) << 3, 0);
            repeat ($urandom_range(10, 12))
                buf_q.insert(buf_q.size(), 8'($urandom) | 8'h80);
        end else begin
            repeat ($urandom_range(1, 5)) gen_field();
            if (r == 2) begin
                buf_q.insert(buf_q.size(), 8'($urandom) | 8'h80);
            end else if (r < 5 && buf_q.size() > 1) begin
                drop = $urandom_range(1, (buf_q.size() > 4) ? 3 : buf_q.size() - 1);
                repeat (drop) void'(buf_q.pop_back());
            end
        end
    endtask

    task automatic flush_buffer(input bit close);
        byte_word_t w;
        if (buf_q.size() == 0)
            buf_q.insert(0, 8'($urandom));
        foreach (buf_q[i]) begin
            w.value = buf_q[i];
            w.last  = close && (i == buf_q.size() - 1);
            pending_words.insert(pending_words.size(), w);
        end
        buf_q.delete();
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_busy || exp_results.size() != 0)
            @(posedge i_clk);
        // Bytes that cause no result may still be inside the block.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_target(input logic [31:0] t);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= t;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        target_q = t;
    endtask

    initial begin
        int          phase_idx;
        int          goal;
        logic [31:0] t;
        clear_scan();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers with the reset target field.
        buf_q = '{8'h38, 8'h01};
        flush_buffer(1'b1);
        buf_q = '{8'h38, 8'h00};
        flush_buffer(1'b1);
        buf_q = '{8'h08, 8'h05};
        flush_buffer(1'b1);
        buf_q = '{8'h3B, 8'h00};
        flush_buffer(1'b1);
        // A tenth varint byte contributes only its lowest bit.
        buf_q.insert(buf_q.size(), 8'h38);
        repeat (9) buf_q.insert(buf_q.size(), 8'h80);
        buf_q.insert(buf_q.size(), 8'h7E);
        flush_buffer(1'b1);
        buf_q = '{8'h12, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h08, 8'h00};
        flush_buffer(1'b1);
        buf_q = '{8'h38};
        flush_buffer(1'b1);
        drain();

        goal = scanned_bytes + RANDOM_BYTES;
        phase_idx = 1;
        while (scanned_bytes < goal) begin
            case (phase_idx)
                1: t = 32'd0;
                2: t = 32'hFFFF_FFFF;
                default: begin
                    case ($urandom_range(0, 5))
                        0: t = 32'd0;
                        1: t = 32'hFFFF_FFFF;
                        2: t = 32'd1;
                        3, 4: t = $urandom_range(1, 40);
                        default: t = $urandom;
                    endcase
                end
            endcase
            write_target(t);
            in_max  = ($urandom_range(0, 3) == 0) ? 0 : 19;
            out_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            if (phase_idx == 3)
                hold_req = 1'b1;
            repeat (7) begin
                gen_buffer();
                flush_buffer(1'b1);
            end
            // Sometimes the buffer stays open across the register write.
            gen_buffer();
            flush_buffer($urandom_range(0, 3) != 0);
            drain();
            phase_idx++;
        end

        drain();
        if (err_cnt == 0)
            $display("protobuf_field_flag_scanner_core: match");
        else
            $display("protobuf_field_flag_scanner_core: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("protobuf_field_flag_scanner_core: mismatch");
        $finish;
    end

endmodule
